/* rtl/wzs_pkg.sv */
// Shared types and constants for the waveform zero suppression block.
package wzs_pkg;

  // Configuration register indexes
  localparam logic [0:0] REG_INITIAL_BASELINE = 1'b0;
  localparam logic [0:0] REG_THRESHOLD        = 1'b1;

  // Reset value of the threshold register
  localparam int THRESHOLD_RESET = 64;

  // Per-transfer control passed from the top level to the datapath parts
  typedef struct packed {
    logic advance;  // item moves from input register to result register
    logic start;    // reload state from the initial baseline first
  } wzs_step_t;

  // Sticky waveform flags
  typedef struct packed {
    logic clip;
    logic above;
    logic below;
    logic keep;
  } wzs_flags_t;

endpackage

/* rtl/wzs_baseline.sv */
// Delay line of past samples with a running sum giving the moving-average baseline.
module wzs_baseline #(
  parameter int ADC_BITS    = 12,
  parameter int WINDOW_LOG2 = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wzs_pkg::wzs_step_t          step,
  input  logic signed [ADC_BITS-1:0]  sample,
  input  logic signed [ADC_BITS-1:0]  init_base,
  output logic signed [ADC_BITS-1:0]  baseline
);

  localparam int Win  = 1 << WINDOW_LOG2;
  localparam int SumW = ADC_BITS + WINDOW_LOG2;

  // Raw samples, oldest at index 0
  logic [ADC_BITS-1:0] hist [Win];
  // Sum of offset-binary samples (each sample plus half scale)
  logic [SumW-1:0]     sum;
  logic [SumW-1:0]     sum_eff;
  logic [SumW-1:0]     sum_next;
  logic [ADC_BITS-1:0] init_off;
  logic [ADC_BITS-1:0] oldest_off;
  logic [ADC_BITS-1:0] new_off;

  // Offset binary: flip the sign bit
  assign init_off = {~init_base[ADC_BITS-1], init_base[ADC_BITS-2:0]};
  assign new_off  = {~sample[ADC_BITS-1], sample[ADC_BITS-2:0]};

  // A start presents a line full of the initial baseline
  always_comb begin
    if (step.start) begin
      sum_eff    = {init_off, {WINDOW_LOG2{1'b0}}};
      oldest_off = init_off;
    end else begin
      sum_eff    = sum;
      oldest_off = {~hist[0][ADC_BITS-1], hist[0][ADC_BITS-2:0]};
    end
    sum_next = sum_eff - {{WINDOW_LOG2{1'b0}}, oldest_off}
                       + {{WINDOW_LOG2{1'b0}}, new_off};
  end

  // Floor of the mean: top bits of the sum, back to two's complement
  assign baseline = {~sum_eff[SumW-1], sum_eff[SumW-2:WINDOW_LOG2]};

  // Delay line and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Win; i++) begin
        hist[i] <= '0;
      end
      sum <= {1'b1, {(SumW-1){1'b0}}};
    end else if (step.advance) begin
      for (int i = 0; i < Win - 1; i++) begin
        hist[i] <= step.start ? init_base : hist[i+1];
      end
      hist[Win-1] <= sample;
      sum         <= sum_next;
    end
  end

endmodule

/* rtl/wzs_stats.sv */
// Amplitude, keep decision, running extremes and sticky flags.
module wzs_stats #(
  parameter int ADC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wzs_pkg::wzs_step_t          step,
  input  logic signed [ADC_BITS-1:0]  sample,
  input  logic signed [ADC_BITS-1:0]  baseline,
  input  logic signed [ADC_BITS-1:0]  init_base,
  input  logic        [ADC_BITS-1:0]  threshold,
  output logic                        keep_now,
  output logic signed [ADC_BITS:0]    amplitude,
  output logic signed [ADC_BITS:0]    amp_low,
  output logic        [ADC_BITS-1:0]  amp_high,
  output logic signed [ADC_BITS-1:0]  adc_low,
  output logic signed [ADC_BITS-1:0]  adc_high,
  output wzs_pkg::wzs_flags_t         flags
);

  logic signed [ADC_BITS:0]   amp_min;
  logic        [ADC_BITS-1:0] amp_max;
  logic signed [ADC_BITS-1:0] adc_min;
  logic signed [ADC_BITS-1:0] adc_max;
  wzs_pkg::wzs_flags_t        sticky;

  logic signed [ADC_BITS:0]   amp_min_eff;
  logic        [ADC_BITS-1:0] amp_max_eff;
  logic signed [ADC_BITS-1:0] adc_min_eff;
  logic signed [ADC_BITS-1:0] adc_max_eff;
  wzs_pkg::wzs_flags_t        sticky_eff;
  wzs_pkg::wzs_flags_t        cur;
  logic signed [ADC_BITS+1:0] amp_x;
  logic signed [ADC_BITS+1:0] thr_x;

  // Sample minus baseline
  assign amplitude = {sample[ADC_BITS-1], sample} - {baseline[ADC_BITS-1], baseline};
  assign amp_x     = {amplitude[ADC_BITS], amplitude};
  assign thr_x     = {2'b00, threshold};

  // Per-sample flags
  always_comb begin
    cur.clip  = (sample == {1'b1, {(ADC_BITS-1){1'b0}}}) ||
                (sample == {1'b0, {(ADC_BITS-1){1'b1}}});
    cur.above = amp_x >= thr_x;
    cur.below = amp_x <= -thr_x;
    cur.keep  = cur.above || cur.below || cur.clip;
  end
  assign keep_now = cur.keep;

  // State as seen by this item, after an optional start
  always_comb begin
    if (step.start) begin
      amp_min_eff = '0;
      amp_max_eff = '0;
      adc_min_eff = init_base;
      adc_max_eff = init_base;
      sticky_eff  = '0;
    end else begin
      amp_min_eff = amp_min;
      amp_max_eff = amp_max;
      adc_min_eff = adc_min;
      adc_max_eff = adc_max;
      sticky_eff  = sticky;
    end
  end

  // Updated extremes and flags
  always_comb begin
    amp_low  = (amplitude < amp_min_eff) ? amplitude : amp_min_eff;
    amp_high = (amplitude > $signed({1'b0, amp_max_eff})) ? amplitude[ADC_BITS-1:0]
                                                          : amp_max_eff;
    adc_low  = (sample < adc_min_eff) ? sample : adc_min_eff;
    adc_high = (sample > adc_max_eff) ? sample : adc_max_eff;
    flags    = sticky_eff | cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_min <= '0;
      amp_max <= '0;
      adc_min <= '0;
      adc_max <= '0;
      sticky  <= '0;
    end else if (step.advance) begin
      amp_min <= amp_low;
      amp_max <= amp_high;
      adc_min <= adc_low;
      adc_max <= adc_high;
      sticky  <= flags;
    end
  end

endmodule

/* rtl/waveform_zero_suppression.sv */
// Top level: waveform zero suppression with a moving-average baseline.
//
// Input channel: in_valid/in_ready carry one signed ADC sample and a start
// flag per transfer. A start reloads the delay line and raw minimum/maximum
// from initial_baseline and clears the amplitude extremes and sticky flags
// before that sample is processed.
// Output channel: out_valid/out_ready carry one result per input transfer,
// in order: keep flag, amplitude, baseline, extremes and sticky flags.
// The input transfer loads the input register; the item then moves to the
// result register, which raises out_valid. Throughput is one item per cycle
// while out_ready holds; the running sum over the delay line keeps the
// baseline a single add and subtract.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that in_ready drops until out_ready.
// Reset clears both stages, the delay line and all running state to zero,
// sets initial_baseline to 0 and threshold to 64.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while
// idle, unenforced by the block. Index 0 is initial_baseline, 1 is threshold.
module waveform_zero_suppression #(
  parameter int ADC_BITS    = 12,
  parameter int WINDOW_LOG2 = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [ADC_BITS-1:0]         cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [ADC_BITS-1:0]  sample,
  input  logic                        start_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        keep_now,
  output logic signed [ADC_BITS:0]    amplitude,
  output logic signed [ADC_BITS-1:0]  baseline,
  output logic signed [ADC_BITS:0]    amp_low,
  output logic        [ADC_BITS-1:0]  amp_high,
  output logic signed [ADC_BITS-1:0]  adc_low,
  output logic signed [ADC_BITS-1:0]  adc_high,
  output logic                        clip_seen,
  output logic                        above_seen,
  output logic                        below_seen,
  output logic                        keep_seen
);

  // Configuration registers
  logic signed [ADC_BITS-1:0] init_base;
  logic        [ADC_BITS-1:0] threshold;

  // Input register
  logic                       in_full;
  logic signed [ADC_BITS-1:0] smp_q;
  logic                       start_q;

  wzs_pkg::wzs_step_t         step;
  logic signed [ADC_BITS-1:0] base_c;
  logic                       keep_c;
  logic signed [ADC_BITS:0]   amp_c;
  logic signed [ADC_BITS:0]   amp_low_c;
  logic        [ADC_BITS-1:0] amp_high_c;
  logic signed [ADC_BITS-1:0] adc_low_c;
  logic signed [ADC_BITS-1:0] adc_high_c;
  wzs_pkg::wzs_flags_t        flags_c;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      init_base <= '0;
      threshold <= ADC_BITS'(wzs_pkg::THRESHOLD_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        wzs_pkg::REG_INITIAL_BASELINE: init_base <= cfg_data;
        wzs_pkg::REG_THRESHOLD:        threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item moves on when the result register is free or being emptied
  assign step.advance = in_full && (!out_valid || out_ready);
  assign step.start   = start_q;
  assign in_ready     = !in_full || step.advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_q   <= sample;
      start_q <= start_req;
    end
  end

  wzs_baseline #(
    .ADC_BITS    (ADC_BITS),
    .WINDOW_LOG2 (WINDOW_LOG2)
  ) u_baseline (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .sample    (smp_q),
    .init_base (init_base),
    .baseline  (base_c)
  );

  wzs_stats #(
    .ADC_BITS (ADC_BITS)
  ) u_stats (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .sample    (smp_q),
    .baseline  (base_c),
    .init_base (init_base),
    .threshold (threshold),
    .keep_now  (keep_c),
    .amplitude (amp_c),
    .amp_low   (amp_low_c),
    .amp_high  (amp_high_c),
    .adc_low   (adc_low_c),
    .adc_high  (adc_high_c),
    .flags     (flags_c)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step.advance) begin
      keep_now   <= keep_c;
      amplitude  <= amp_c;
      baseline   <= base_c;
      amp_low    <= amp_low_c;
      amp_high   <= amp_high_c;
      adc_low    <= adc_low_c;
      adc_high   <= adc_high_c;
      clip_seen  <= flags_c.clip;
      above_seen <= flags_c.above;
      below_seen <= flags_c.below;
      keep_seen  <= flags_c.keep;
    end
  end

  // Every item leaving the input register lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    step.advance |=> out_valid)
    else $error("advanced item did not reach the result register");

  // Input side only blocks when both stages are occupied
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // A kept sample always sets the sticky keep flag
  a_keep_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && keep_now) |-> keep_seen)
    else $error("keep_now without keep_seen");

  // Amplitude lies within the tracked amplitude extremes
  a_amp_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((amp_low <= amplitude) &&
                   (amplitude <= $signed({1'b0, amp_high}))))
    else $error("amplitude outside tracked extremes");

  // Raw extremes stay ordered
  a_adc_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (adc_low <= adc_high))
    else $error("raw minimum above raw maximum");

endmodule
